@@ design/lswlf_pkg.sv @@
// ----------------------------------------------------------------------------
// lswlf_pkg
// Shared constants and types for the line-scan white line finder.
// ----------------------------------------------------------------------------
package lswlf_pkg;

	localparam int WINDOW_LEN  = 8;
	localparam int LINE_PIXELS = 128;

	localparam int SAMPLE_W = 12;
	localparam int THR_W    = 12;
	localparam int MLW_W    = 8;
	localparam int DIFF_W   = SAMPLE_W + 1;
	localparam int SUM_W    = SAMPLE_W + 2;
	localparam int IDX_W    = 10;
	localparam int CNT_W    = MLW_W + 1;
	localparam int POS_W    = IDX_W + 1;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = THR_W;

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(512);
	localparam logic [MLW_W-1:0] MLW_RESET = MLW_W'(16);

	localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LINE_WIDTH = CFG_IDX_W'(1);

	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic signed [POS_W-1:0]  pos_t;

endpackage

@@ design/line_scan_white_line_finder_unit.sv @@
// ----------------------------------------------------------------------------
// line_scan_white_line_finder_unit
// Finds a white line in a line-scan sensor row from windowed pixel differences.
// ----------------------------------------------------------------------------
// Input channel: sample, first_pixel, last_pixel with in_valid / in_stall.
// One pixel is taken per clock unless in_stall is high. first_pixel restarts
// the scan: it clears the difference window, the window sum and the detector
// flags. Every other pixel updates an 8-deep shift line of differences and its
// running sum, and the edge detector (rise arms a width countdown, fall while
// armed records the line position at pixel index minus the window length).
// Output channel: line_position, line_found with out_valid / out_stall. A pixel
// marked last_pixel yields one item, registered, out_valid rising in the cycle
// after the pixel is taken. All other pixels yield nothing.
// Throughput: one pixel per cycle while in_stall is low; the window and detector
// state registers update from the accepted pixel. in_stall rises only when a last_pixel
// item is offered while the result register is full and the receiver stalls;
// pixels without last_pixel keep flowing.
// Configuration: cfg_we / cfg_index / cfg_data, written at any rising edge
// with cfg_we high, index 0 edge_threshold, index 1 max_line_width.
// Reset (arst_n low): threshold 512, width 16, window and flags cleared,
// line marked lost, held position 0, no result pending.
// ----------------------------------------------------------------------------
module line_scan_white_line_finder_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [lswlf_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [lswlf_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [lswlf_pkg::SAMPLE_W-1:0]         sample,
	input  logic                                   first_pixel,
	input  logic                                   last_pixel,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [lswlf_pkg::POS_W-1:0]     line_position,
	output logic                                   line_found
);

	logic [lswlf_pkg::THR_W-1:0]    thr_q;
	logic [lswlf_pkg::MLW_W-1:0]    mlw_q;
	lswlf_pkg::diff_t               win_q [lswlf_pkg::WINDOW_LEN];
	lswlf_pkg::sum_t                sum_q;
	logic [lswlf_pkg::SAMPLE_W-1:0] prev_q;
	logic [lswlf_pkg::IDX_W-1:0]    idx_q;
	logic                           armed_q;
	logic [lswlf_pkg::CNT_W-1:0]    cnt_q;
	logic                           lost_q;
	lswlf_pkg::pos_t                held_q;
	logic                           out_valid_q;
	lswlf_pkg::pos_t                pos_q;
	logic                           found_q;

	logic                           accept;
	lswlf_pkg::diff_t               diff;
	lswlf_pkg::sum_t                sum_d;
	lswlf_pkg::sum_t                thr_s;
	logic [lswlf_pkg::IDX_W-1:0]    idx_d;
	logic                           armed_d;
	logic [lswlf_pkg::CNT_W-1:0]    cnt_d;
	logic                           lost_d;
	lswlf_pkg::pos_t                held_d;

	assign accept   = in_valid && !in_stall;
	assign in_stall = out_valid_q && out_stall && last_pixel;

	always_comb begin
		diff    = lswlf_pkg::diff_t'({1'b0, sample}) - lswlf_pkg::diff_t'({1'b0, prev_q});
		thr_s   = lswlf_pkg::sum_t'({2'b00, thr_q});
		sum_d   = sum_q - lswlf_pkg::sum_t'(win_q[lswlf_pkg::WINDOW_LEN-1])
			+ lswlf_pkg::sum_t'(diff);
		idx_d   = idx_q + lswlf_pkg::IDX_W'(1);
		armed_d = armed_q;
		cnt_d   = cnt_q;
		lost_d  = lost_q;
		held_d  = held_q;
		if (first_pixel) begin
			sum_d   = '0;
			idx_d   = '0;
			armed_d = 1'b0;
			cnt_d   = '0;
			lost_d  = 1'b1;
		end else begin
			if (sum_d > thr_s) begin
				armed_d = 1'b1;
				cnt_d   = {1'b0, mlw_q};
			end
			if (armed_d) begin
				if (cnt_d == '0)
					armed_d = 1'b0;
				cnt_d = cnt_d - lswlf_pkg::CNT_W'(1);
			end
			if ((-sum_d > thr_s) && armed_d) begin
				armed_d = 1'b0;
				lost_d  = 1'b0;
				held_d  = lswlf_pkg::pos_t'({1'b0, idx_d})
					- lswlf_pkg::pos_t'(lswlf_pkg::WINDOW_LEN);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= lswlf_pkg::THR_RESET;
			mlw_q <= lswlf_pkg::MLW_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				lswlf_pkg::REG_EDGE_THRESHOLD: thr_q <= cfg_data[lswlf_pkg::THR_W-1:0];
				lswlf_pkg::REG_MAX_LINE_WIDTH: mlw_q <= cfg_data[lswlf_pkg::MLW_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < lswlf_pkg::WINDOW_LEN; k++)
				win_q[k] <= '0;
			sum_q   <= '0;
			prev_q  <= '0;
			idx_q   <= '0;
			armed_q <= 1'b0;
			cnt_q   <= '0;
			lost_q  <= 1'b1;
			held_q  <= '0;
		end else if (accept) begin
			if (first_pixel) begin
				for (int k = 0; k < lswlf_pkg::WINDOW_LEN; k++)
					win_q[k] <= '0;
			end else begin
				win_q[0] <= diff;
				for (int k = 1; k < lswlf_pkg::WINDOW_LEN; k++)
					win_q[k] <= win_q[k-1];
			end
			sum_q   <= sum_d;
			prev_q  <= sample;
			idx_q   <= idx_d;
			armed_q <= armed_d;
			cnt_q   <= cnt_d;
			lost_q  <= lost_d;
			held_q  <= held_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && last_pixel) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_pixel) begin
			pos_q   <= held_d;
			found_q <= !lost_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign line_position = pos_q;
	assign line_found    = found_q;

	a_last_gives_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_pixel |=> out_valid)
		else $error("last pixel produced no result item");

	a_first_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && first_pixel |=> lost_q && !armed_q && sum_q == '0 && idx_q == '0)
		else $error("first pixel did not clear scan state");

	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_q >= -lswlf_pkg::pos_t'(lswlf_pkg::WINDOW_LEN))
		else $error("held position below window offset");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid_q && last_pixel)
		else $error("input stalled without a pending result");

endmodule

@@ sim/line_scan_white_line_finder_unit_tb.sv @@
// ----------------------------------------------------------------------------
// line_scan_white_line_finder_unit_tb
// Self-checking bench for the line-scan white line finder.
// Scan lines of pixels go in through the valid/stall input channel. A local
// model of the window sum and the edge detector predicts each scan result.
// The checker compares every result it receives, in order, with the model.
// Directed cases come first. Register sweeps and a long output hold-off
// follow. The run ends with random scans and noise, with random idling on
// both sides in all but the middle phase.
// ----------------------------------------------------------------------------
module line_scan_white_line_finder_unit_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		lswlf_pkg::pos_t position;
		logic            found;
	} scan_result_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_we = 1'b0;
	logic [lswlf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [lswlf_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                             in_valid = 1'b0;
	logic                             in_stall;
	logic [lswlf_pkg::SAMPLE_W-1:0]   sample = '0;
	logic                             first_pixel = 1'b0;
	logic                             last_pixel = 1'b0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	lswlf_pkg::pos_t                  line_position;
	logic                             line_found;

	line_scan_white_line_finder_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.first_pixel(first_pixel),
		.last_pixel(last_pixel),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.line_position(line_position),
		.line_found(line_found)
	);

	// finder model state
	int                             diff_win[lswlf_pkg::WINDOW_LEN];
	int                             win_sum;
	logic [lswlf_pkg::SAMPLE_W-1:0] prev_sample;
	logic [lswlf_pkg::IDX_W-1:0]    pix_idx;
	logic                           armed;
	logic [lswlf_pkg::CNT_W-1:0]    countdown;
	logic                           lost;
	lswlf_pkg::pos_t                held_pos;
	int                             slot_ptr;
	logic [lswlf_pkg::THR_W-1:0]    thr_reg;
	logic [lswlf_pkg::MLW_W-1:0]    mlw_reg;

	scan_result_t expected_scans[$];

	int  errors = 0;
	int  pixels_sent = 0;
	int  scans_expected = 0;
	int  scans_checked = 0;
	int  cycle_count = 0;
	int  hold_left = 0;
	bit  hold_start = 0;
	bit  calm = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d scans outstanding", cycle_count,
				expected_scans.size());
			$display("FAILURE");
			$finish;
		end
	end

	task automatic clear_scan_state();
		for (int k = 0; k < lswlf_pkg::WINDOW_LEN; k++)
			diff_win[k] = 0;
		win_sum = 0;
		armed = 1'b0;
		countdown = '0;
		lost = 1'b1;
		pix_idx = '0;
		slot_ptr = 0;
	endtask

	task automatic model_reset();
		thr_reg = lswlf_pkg::THR_RESET;
		mlw_reg = lswlf_pkg::MLW_RESET;
		clear_scan_state();
		prev_sample = '0;
		held_pos = '0;
	endtask

	task automatic advance_finder(input logic [lswlf_pkg::SAMPLE_W-1:0] s_val,
			input logic is_first, input logic is_last);
		int d;
		scan_result_t r;
		if (is_first) begin
			clear_scan_state();
		end else begin
			d = int'(s_val) - int'(prev_sample);
			pix_idx = pix_idx + lswlf_pkg::IDX_W'(1);
			slot_ptr = (slot_ptr + 1) % lswlf_pkg::WINDOW_LEN;
			win_sum = win_sum - diff_win[slot_ptr] + d;
			diff_win[slot_ptr] = d;
			if (win_sum > int'(thr_reg)) begin
				armed = 1'b1;
				countdown = lswlf_pkg::CNT_W'(mlw_reg);
			end
			if (armed) begin
				if (countdown == '0)
					armed = 1'b0;
				countdown = countdown - lswlf_pkg::CNT_W'(1);
			end
			if (-win_sum > int'(thr_reg) && armed) begin
				armed = 1'b0;
				lost = 1'b0;
				held_pos = lswlf_pkg::pos_t'(int'(pix_idx) - lswlf_pkg::WINDOW_LEN);
			end
		end
		prev_sample = s_val;
		if (is_last) begin
			r.position = held_pos;
			r.found = ~lost;
			expected_scans.push_back(r);
			scans_expected++;
		end
	endtask

	always @(posedge clk) begin
		scan_result_t e;
		if (out_valid && !out_stall) begin
			if (expected_scans.size() == 0) begin
				$display("%0t: unexpected scan result, actual position %0d found %0b",
					$time, line_position, line_found);
				errors++;
			end else begin
				e = expected_scans.pop_front();
				if (line_position !== e.position) begin
					$display("%0t: line_position mismatch, expected %0d, actual %0d",
						$time, e.position, line_position);
					errors++;
				end
				if (line_found !== e.found) begin
					$display("%0t: line_found mismatch, expected %0b, actual %0b",
						$time, e.found, line_found);
					errors++;
				end
			end
			scans_checked++;
		end
		if (hold_start) begin
			hold_left = HOLD_CYCLES;
			hold_start = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(0, 99) < 24);
		end
	end

	task automatic send_pixel(input logic [lswlf_pkg::SAMPLE_W-1:0] s_val,
			input logic is_first, input logic is_last);
		while (!calm && $urandom_range(0, 99) < 24) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= s_val;
		first_pixel <= is_first;
		last_pixel <= is_last;
		do
			@(posedge clk);
		while (in_stall);
		advance_finder(s_val, is_first, is_last);
		pixels_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_scans.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [lswlf_pkg::CFG_IDX_W-1:0] idx,
			input logic [lswlf_pkg::CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == lswlf_pkg::REG_EDGE_THRESHOLD)
			thr_reg = val[lswlf_pkg::THR_W-1:0];
		else
			mlw_reg = val[lswlf_pkg::MLW_W-1:0];
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input int thr, input int mlw);
		write_reg(lswlf_pkg::REG_EDGE_THRESHOLD, lswlf_pkg::CFG_DATA_W'(thr));
		write_reg(lswlf_pkg::REG_MAX_LINE_WIDTH, lswlf_pkg::CFG_DATA_W'(mlw));
	endtask

	function automatic logic [lswlf_pkg::SAMPLE_W-1:0] clip_sample(input int v);
		if (v > 4095)
			return lswlf_pkg::SAMPLE_W'(4095);
		if (v < 0)
			return '0;
		return lswlf_pkg::SAMPLE_W'(v);
	endfunction

	// one scan line: dark background with a bright stripe
	task automatic send_scan(input int len, input int stripe_at, input int stripe_w,
			input int dark, input int bright, input int noise, input bit with_last);
		int level;
		send_pixel(clip_sample(dark + $urandom_range(0, noise)), 1'b1, len == 1 && with_last);
		for (int k = 1; k < len; k++) begin
			level = (k >= stripe_at && k < stripe_at + stripe_w) ? bright : dark;
			send_pixel(clip_sample(level + $urandom_range(0, noise)), 1'b0,
				with_last && k == len - 1);
		end
	endtask

	task automatic send_random_scan();
		int len;
		int dark;
		len = $urandom_range(10, 48);
		dark = $urandom_range(0, 1500);
		send_scan(len, $urandom_range(1, len - 1), $urandom_range(1, 24), dark,
			dark + $urandom_range(0, 4095 - dark), $urandom_range(0, 63),
			$urandom_range(0, 99) < 92);
	endtask

	task automatic send_noise();
		int n;
		n = $urandom_range(1, 12);
		repeat (n)
			send_pixel(lswlf_pkg::SAMPLE_W'($urandom_range(0, 4095)),
				$urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
	endtask

	task automatic test_directed();
		// pixels before any first pixel
		send_pixel(lswlf_pkg::SAMPLE_W'(0), 1'b0, 1'b0);
		send_pixel(lswlf_pkg::SAMPLE_W'(4095), 1'b0, 1'b0);
		send_pixel(lswlf_pkg::SAMPLE_W'(4095), 1'b0, 1'b0);
		send_pixel(lswlf_pkg::SAMPLE_W'(0), 1'b0, 1'b1);
		// first and last together
		send_pixel(lswlf_pkg::SAMPLE_W'(4095), 1'b1, 1'b1);
		// clean stripe, found
		send_scan(15, 4, 4, 100, 3000, 0, 1'b1);
		// flat line, not found, held position kept
		send_scan(4, 0, 0, 2048, 2048, 0, 1'b1);
		// pixels after last without a new first pixel
		send_pixel(lswlf_pkg::SAMPLE_W'(0), 1'b0, 1'b0);
		send_pixel(lswlf_pkg::SAMPLE_W'(4095), 1'b0, 1'b1);
		drain();
	endtask

	task automatic test_register_sweep();
		int thr_set[6] = '{0, 4095, 0, 4095, 1, 2047};
		int mlw_set[6] = '{0, 255, 255, 0, 1, 8};
		for (int p = 0; p < 6; p++) begin
			configure(thr_set[p], mlw_set[p]);
			repeat (2) send_random_scan();
			drain();
		end
		configure(512, 16);
	endtask

	task automatic test_output_hold();
		hold_start = 1;
		repeat (40) send_pixel(lswlf_pkg::SAMPLE_W'($urandom_range(0, 4095)), 1'b1, 1'b1);
		repeat (3) send_random_scan();
		drain();
	endtask

	task automatic test_random();
		int phase_items;
		for (int phase = 0; phase < 3; phase++) begin
			configure($urandom_range(0, 4095) >> $urandom_range(0, 4),
				$urandom_range(0, 255) >> $urandom_range(0, 3));
			calm = (phase == 1);
			phase_items = pixels_sent;
			while (pixels_sent - phase_items < 60) begin
				if ($urandom_range(0, 99) < 75)
					send_random_scan();
				else
					send_noise();
			end
			drain();
			calm = 0;
		end
	endtask

	initial begin
		model_reset();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_register_sweep();
		test_output_hold();
		test_random();
		drain();
		repeat (16) @(posedge clk);
		$display("covered %0d pixels, %0d of %0d scan results: directed cases,",
			pixels_sent, scans_checked, scans_expected);
		$display("register extremes, output hold-off and random scans with noise");
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
